/* design/fdsta_pkg.sv */
// Shared types, register codes and saturation helpers for the stencil triplet assembler.
package fdsta_pkg;

    typedef enum logic [3:0] {
        CFG_TIME_STEP   = 4'd0,
        CFG_STEP_DIM0   = 4'd1,
        CFG_STEP_DIM1   = 4'd2,
        CFG_LOWER_DIM0  = 4'd3,
        CFG_LOWER_DIM1  = 4'd4,
        CFG_POINTS_DIM0 = 4'd5,
        CFG_POINTS_DIM1 = 4'd6,
        CFG_STEADY_MODE = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        [30:0] time_step;
        logic        [30:0] step_dim0;
        logic        [30:0] step_dim1;
        logic signed [31:0] lower_dim0;
        logic signed [31:0] lower_dim1;
        logic        [12:0] points_dim0;
        logic        [12:0] points_dim1;
        logic               steady_mode;
    } t_cfg;

    typedef struct packed {
        logic        [23:0] row_index;
        logic signed [31:0] coord_dim0;
        logic signed [31:0] coord_dim1;
        logic signed [31:0] level_coef;
        logic signed [31:0] drift_dim0;
        logic signed [31:0] drift_dim1;
        logic signed [31:0] diffusion_dim0;
        logic signed [31:0] diffusion_dim1;
    } t_in_item;

    typedef struct packed {
        logic        [23:0] out_row;
        logic        [23:0] out_col;
        logic signed [31:0] out_value;
        logic               last_triplet;
    } t_out_item;

    typedef struct packed {
        logic        [23:0] row;
        logic signed [31:0] diag;
        logic        [1:0]  e_up;
        logic        [1:0]  e_lo;
        logic        [1:0]  bpos;
        logic        [1:0]  bneg;
    } t_side;

    typedef struct packed {
        logic [63:0] num;
        logic [61:0] den;
        logic        neg;
    } t_lane;

    typedef struct packed {
        logic            vld;
        t_side           side;
        t_lane [3:0]     lane;
    } t_div_req;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        logic        vld;
        t_side       side;
        t_q [3:0]    val;
    } t_coef;

    function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] mag);
        if (!neg) begin
            return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
        end
        if (mag > 64'h8000_0000) begin
            return 32'sh8000_0000;
        end
        return $signed(~mag[31:0] + 32'd1);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

endpackage

/* design/fd_stencil_triplet_assembler.sv */
// Throughput: one triplet per cycle while the output is not stalled; a grid point yields
// 7, 10 or 13 triplets by how many dims lie on an edge; the single output port sets this rate.
// Reset is synchronous and active low; it empties the pipeline and loads register defaults.
// Top level: configuration registers and the front, divider and sequencer pipeline.
module fd_stencil_triplet_assembler #(
    parameter int DIMS       = 2,
    parameter int INDEX_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fdsta_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fdsta_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [3:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import fdsta_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step   <= 31'd65536;
            r_cfg.step_dim0   <= 31'd65536;
            r_cfg.step_dim1   <= 31'd65536;
            r_cfg.lower_dim0  <= '0;
            r_cfg.lower_dim1  <= '0;
            r_cfg.points_dim0 <= 13'd64;
            r_cfg.points_dim1 <= 13'd64;
            r_cfg.steady_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIME_STEP:   r_cfg.time_step   <= i_cfg_data[30:0];
                CFG_STEP_DIM0:   r_cfg.step_dim0   <= i_cfg_data[30:0];
                CFG_STEP_DIM1:   r_cfg.step_dim1   <= i_cfg_data[30:0];
                CFG_LOWER_DIM0:  r_cfg.lower_dim0  <= i_cfg_data;
                CFG_LOWER_DIM1:  r_cfg.lower_dim1  <= i_cfg_data;
                CFG_POINTS_DIM0: r_cfg.points_dim0 <= i_cfg_data[12:0];
                CFG_POINTS_DIM1: r_cfg.points_dim1 <= i_cfg_data[12:0];
                CFG_STEADY_MODE: r_cfg.steady_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    t_div_req w_req;
    t_coef    w_coef;
    logic     w_can_load;
    logic     w_en_front;

    assign w_en_front = !w_coef.vld || w_can_load;
    assign o_in_stall = !w_en_front;

    fdsta_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en_front),
        .i_cfg   (r_cfg),
        .i_vld   (i_in_valid),
        .i_item  (i_in_data),
        .o_req   (w_req)
    );

    fdsta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en_front),
        .i_req   (w_req),
        .o_coef  (w_coef)
    );

    fdsta_emit #(
        .DIMS       (DIMS),
        .INDEX_BITS (INDEX_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_coef      (w_coef),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* design/fdsta_prep.sv */
// Front stages: products, edge tests, diagonal value and divider operands.
module fdsta_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  fdsta_pkg::t_cfg     i_cfg,
    input  logic                i_vld,
    input  fdsta_pkg::t_in_item i_item,
    output fdsta_pkg::t_div_req o_req
);
    import fdsta_pkg::*;

    logic [30:0] w_h0, w_h1;
    assign w_h0 = (i_cfg.step_dim0 == '0) ? 31'd1 : i_cfg.step_dim0;
    assign w_h1 = (i_cfg.step_dim1 == '0) ? 31'd1 : i_cfg.step_dim1;

    // Stage A
    logic     r_a_vld;
    t_in_item r_a_item;

    // Stage B
    logic signed [13:0] w_pm0, w_pm1;
    logic signed [45:0] w_hm0, w_hm1;
    logic        [61:0] w_hsq0, w_hsq1;
    logic signed [63:0] w_dta;
    assign w_pm0  = $signed({1'b0, i_cfg.points_dim0}) - 14'sd1;
    assign w_pm1  = $signed({1'b0, i_cfg.points_dim1}) - 14'sd1;
    assign w_hm0  = $signed({1'b0, w_h0}) * w_pm0;
    assign w_hm1  = $signed({1'b0, w_h1}) * w_pm1;
    assign w_hsq0 = w_h0 * w_h0;
    assign w_hsq1 = w_h1 * w_h1;
    assign w_dta  = $signed({1'b0, i_cfg.time_step}) * r_a_item.level_coef;

    logic               r_b_vld;
    logic        [23:0] r_b_row;
    logic signed [31:0] r_b_c0, r_b_c1;
    logic signed [45:0] r_b_hm0, r_b_hm1;
    logic        [61:0] r_b_hsq0, r_b_hsq1;
    logic signed [63:0] r_b_dta;
    logic        [31:0] r_b_bmag0, r_b_bmag1, r_b_cmag0, r_b_cmag1;
    logic        [1:0]  r_b_bpos, r_b_bneg, r_b_cneg;

    // Stage C
    logic               r_c_vld;
    logic        [23:0] r_c_row;
    logic signed [31:0] r_c_c0, r_c_c1;
    logic signed [46:0] r_c_up0, r_c_up1;
    logic signed [63:0] r_c_v;
    logic        [1:0]  r_c_bpos, r_c_bneg;
    t_lane       [3:0]  r_c_lane;

    // Stage D
    logic signed [47:0] w_du0, w_du1, w_dl0, w_dl1;
    logic        [47:0] w_mu0, w_mu1, w_ml0, w_ml1;
    logic               w_up0, w_up1, w_lo0, w_lo1;
    logic        [63:0] w_vmag;
    assign w_du0 = r_c_c0 - r_c_up0;
    assign w_du1 = r_c_c1 - r_c_up1;
    assign w_dl0 = r_c_c0 - i_cfg.lower_dim0;
    assign w_dl1 = r_c_c1 - i_cfg.lower_dim1;
    assign w_mu0 = w_du0[47] ? (~w_du0 + 48'd1) : w_du0;
    assign w_mu1 = w_du1[47] ? (~w_du1 + 48'd1) : w_du1;
    assign w_ml0 = w_dl0[47] ? (~w_dl0 + 48'd1) : w_dl0;
    assign w_ml1 = w_dl1[47] ? (~w_dl1 + 48'd1) : w_dl1;
    assign w_up0 = {w_mu0, 1'b0} < 49'(w_h0);
    assign w_up1 = {w_mu1, 1'b0} < 49'(w_h1);
    assign w_lo0 = {w_ml0, 1'b0} < 49'(w_h0);
    assign w_lo1 = {w_ml1, 1'b0} < 49'(w_h1);
    assign w_vmag = mag64(r_c_v);

    logic        r_d_vld;
    t_side       r_d_side;
    t_lane [3:0] r_d_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;

            r_b_row   <= r_a_item.row_index;
            r_b_c0    <= r_a_item.coord_dim0;
            r_b_c1    <= r_a_item.coord_dim1;
            r_b_hm0   <= w_hm0;
            r_b_hm1   <= w_hm1;
            r_b_hsq0  <= w_hsq0;
            r_b_hsq1  <= w_hsq1;
            r_b_dta   <= w_dta;
            r_b_bmag0 <= mag32(r_a_item.drift_dim0);
            r_b_bmag1 <= mag32(r_a_item.drift_dim1);
            r_b_cmag0 <= mag32(r_a_item.diffusion_dim0);
            r_b_cmag1 <= mag32(r_a_item.diffusion_dim1);
            r_b_bneg  <= {r_a_item.drift_dim1[31], r_a_item.drift_dim0[31]};
            r_b_bpos  <= {!r_a_item.drift_dim1[31] && (r_a_item.drift_dim1 != '0),
                          !r_a_item.drift_dim0[31] && (r_a_item.drift_dim0 != '0)};
            r_b_cneg  <= {r_a_item.diffusion_dim1[31], r_a_item.diffusion_dim0[31]};

            r_c_row  <= r_b_row;
            r_c_c0   <= r_b_c0;
            r_c_c1   <= r_b_c1;
            r_c_up0  <= i_cfg.lower_dim0 + r_b_hm0;
            r_c_up1  <= i_cfg.lower_dim1 + r_b_hm1;
            r_c_v    <= (i_cfg.steady_mode ? 64'sd0 : 64'sh1_0000_0000) - r_b_dta;
            r_c_bpos <= r_b_bpos;
            r_c_bneg <= r_b_bneg;
            r_c_lane[0].num <= {16'b0, r_b_bmag0, 16'b0} + 64'(w_h0 >> 1);
            r_c_lane[0].den <= 62'(w_h0);
            r_c_lane[0].neg <= r_b_bneg[0];
            r_c_lane[1].num <= {r_b_cmag0, 32'b0} + 64'(r_b_hsq0 >> 1);
            r_c_lane[1].den <= r_b_hsq0;
            r_c_lane[1].neg <= r_b_cneg[0];
            r_c_lane[2].num <= {16'b0, r_b_bmag1, 16'b0} + 64'(w_h1 >> 1);
            r_c_lane[2].den <= 62'(w_h1);
            r_c_lane[2].neg <= r_b_bneg[1];
            r_c_lane[3].num <= {r_b_cmag1, 32'b0} + 64'(r_b_hsq1 >> 1);
            r_c_lane[3].den <= r_b_hsq1;
            r_c_lane[3].neg <= r_b_cneg[1];

            r_d_side.row  <= r_c_row;
            r_d_side.diag <= sat32(r_c_v[63], (w_vmag + 64'd32768) >> 16);
            r_d_side.e_up <= {w_up1, w_up0};
            r_d_side.e_lo <= {!w_up1 && w_lo1, !w_up0 && w_lo0};
            r_d_side.bpos <= r_c_bpos;
            r_d_side.bneg <= r_c_bneg;
            r_d_lane      <= r_c_lane;
        end
    end

    assign o_req.vld  = r_d_vld;
    assign o_req.side = r_d_side;
    assign o_req.lane = r_d_lane;

endmodule

/* design/fdsta_div.sv */
// Four-lane pipelined saturating divider, two quotient bits per stage.
module fdsta_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  fdsta_pkg::t_div_req i_req,
    output fdsta_pkg::t_coef    o_coef
);
    import fdsta_pkg::*;

    localparam int STEPS = 16;

    function automatic logic [63:0] div_step2(input logic [61:0] rem, input logic [1:0] nb,
                                              input logic [61:0] den);
        logic [62:0] t;
        logic [61:0] r;
        logic [1:0]  q;
        r = rem;
        q = 2'b00;
        for (int k = 1; k >= 0; k--) begin
            t = {r, nb[k]};
            if (t >= {1'b0, den}) begin
                t    = t - {1'b0, den};
                q[k] = 1'b1;
            end
            r = t[61:0];
        end
        return {r, q};
    endfunction

    logic        r_vld  [0:STEPS];
    t_side       r_side [0:STEPS];
    logic [61:0] r_rem  [0:STEPS][0:3];
    logic [61:0] r_den  [0:STEPS][0:3];
    logic [31:0] r_nlo  [0:STEPS][0:3];
    logic [31:0] r_q    [0:STEPS][0:3];
    logic        r_ovf  [0:STEPS][0:3];
    logic        r_neg  [0:STEPS][0:3];
    logic [63:0] w_step [1:STEPS][0:3];

    always_comb begin
        for (int s = 1; s <= STEPS; s++) begin
            for (int l = 0; l < 4; l++) begin
                w_step[s][l] = div_step2(r_rem[s-1][l], r_nlo[s-1][l][31:30], r_den[s-1][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= STEPS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_req.vld;
            for (int s = 1; s <= STEPS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_req.side;
            for (int l = 0; l < 4; l++) begin
                r_rem[0][l] <= 62'(i_req.lane[l].num[63:32]);
                r_nlo[0][l] <= i_req.lane[l].num[31:0];
                r_den[0][l] <= i_req.lane[l].den;
                r_q[0][l]   <= '0;
                r_ovf[0][l] <= 62'(i_req.lane[l].num[63:32]) >= i_req.lane[l].den;
                r_neg[0][l] <= i_req.lane[l].neg;
            end
            for (int s = 1; s <= STEPS; s++) begin
                r_side[s] <= r_side[s-1];
                for (int l = 0; l < 4; l++) begin
                    r_rem[s][l] <= w_step[s][l][63:2];
                    r_nlo[s][l] <= r_nlo[s-1][l] << 2;
                    r_den[s][l] <= r_den[s-1][l];
                    r_q[s][l]   <= {r_q[s-1][l][29:0], w_step[s][l][1:0]};
                    r_ovf[s][l] <= r_ovf[s-1][l];
                    r_neg[s][l] <= r_neg[s-1][l];
                end
            end
        end
    end

    always_comb begin
        o_coef.vld  = r_vld[STEPS];
        o_coef.side = r_side[STEPS];
        for (int l = 0; l < 4; l++) begin
            o_coef.val[l] = sat32(r_neg[STEPS][l], 64'({r_ovf[STEPS][l], r_q[STEPS][l]}));
        end
    end

endmodule

/* design/fdsta_emit.sv */
// Triplet sequencer with the time-step scaling multiplier and output register.
module fdsta_emit #(
    parameter int DIMS       = 2,
    parameter int INDEX_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fdsta_pkg::t_cfg      i_cfg,
    input  fdsta_pkg::t_coef     i_coef,
    output logic                 o_can_load,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fdsta_pkg::t_out_item o_out_data
);
    import fdsta_pkg::*;

    localparam int W = INDEX_BITS;

    typedef enum logic [2:0] {G_DIAG, G_E1, G_E0, G_I1, G_I0} t_grp;

    logic     r_busy;
    t_grp     r_grp;
    logic [2:0] r_sub;
    t_side    r_side;
    t_q [3:0] r_val;

    logic w_en;
    assign w_en = !o_out_valid || !i_out_stall;

    logic w_e0, w_e1, w_app_e1, w_app_i1;
    assign w_e0     = r_side.e_up[0] || r_side.e_lo[0];
    assign w_e1     = r_side.e_up[1] || r_side.e_lo[1];
    assign w_app_e1 = (DIMS > 1) && w_e1;
    assign w_app_i1 = (DIMS > 1) && !w_e1;

    t_grp       w_next;
    logic       w_more;
    logic [2:0] w_size;
    always_comb begin
        w_next = G_I0;
        w_more = 1'b1;
        w_size = 3'd6;
        case (r_grp)
            G_DIAG: begin
                w_size = 3'd1;
                w_next = w_app_e1 ? G_E1 : (w_e0 ? G_E0 : (w_app_i1 ? G_I1 : G_I0));
            end
            G_E1: begin
                w_size = 3'd3;
                w_next = w_e0 ? G_E0 : G_I0;
            end
            G_E0: begin
                w_size = 3'd3;
                w_next = w_app_i1 ? G_I1 : G_I0;
                w_more = w_app_i1;
            end
            G_I1: begin
                w_more = !w_e0;
            end
            default: begin
                w_more = 1'b0;
            end
        endcase
    end

    logic w_last;
    assign w_last = (r_sub == w_size - 3'd1) && !w_more;
    assign o_can_load = !r_busy || (w_en && w_last);

    logic               w_dim, w_up, w_bpos, w_bneg;
    logic signed [34:0] w_f, w_s, w_k;
    logic [W-1:0]       w_row, w_st, w_col;
    always_comb begin
        w_dim  = (r_grp == G_E1) || (r_grp == G_I1);
        w_f    = w_dim ? r_val[2] : r_val[0];
        w_s    = w_dim ? r_val[3] : r_val[1];
        w_up   = r_side.e_up[w_dim];
        w_bpos = r_side.bpos[w_dim];
        w_bneg = r_side.bneg[w_dim];
        w_row  = W'(r_side.row);
        w_st   = w_dim ? W'(i_cfg.points_dim0) : W'(1);
        w_col  = w_row;
        w_k    = '0;
        case (r_grp)
            G_E1, G_E0: begin
                case (r_sub)
                    3'd0: w_k = w_up ? (w_f + w_s) : (w_s - w_f);
                    3'd1: begin
                        w_col = w_up ? (w_row - w_st) : (w_row + w_st);
                        w_k   = w_up ? (-w_f - (w_s <<< 1)) : (w_f - (w_s <<< 1));
                    end
                    default: begin
                        w_col = w_up ? (w_row - w_st - w_st) : (w_row + w_st + w_st);
                        w_k   = w_s;
                    end
                endcase
            end
            G_I1, G_I0: begin
                case (r_sub)
                    3'd0: w_k = w_bpos ? -w_f : (w_bneg ? w_f : 35'sd0);
                    3'd1: begin
                        w_col = w_row + w_st;
                        w_k   = w_bpos ? w_f : 35'sd0;
                    end
                    3'd2: begin
                        w_col = w_row - w_st;
                        w_k   = w_bneg ? -w_f : 35'sd0;
                    end
                    3'd3: w_k = -(w_s <<< 1);
                    3'd4: begin
                        w_col = w_row + w_st;
                        w_k   = w_s;
                    end
                    default: begin
                        w_col = w_row - w_st;
                        w_k   = w_s;
                    end
                endcase
            end
            default: begin
                w_k = '0;
            end
        endcase
    end

    // Issue stage
    logic               r_e_vld, r_e_direct, r_e_last;
    logic [W-1:0]       r_e_row, r_e_col;
    logic signed [34:0] r_e_k;
    logic signed [31:0] r_e_dval;

    // Multiply stage
    logic               r_m_vld, r_m_direct, r_m_last, r_m_neg;
    logic [W-1:0]       r_m_row, r_m_col;
    logic [64:0]        r_m_prod;
    logic signed [31:0] r_m_dval;

    logic [33:0] w_kmag;
    logic [64:0] w_rnd;
    assign w_kmag = r_e_k[34] ? 34'(~r_e_k + 35'sd1) : 34'(r_e_k);
    assign w_rnd  = (r_m_prod + 65'd32768) >> 16;

    logic      r_o_vld;
    t_out_item r_o_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_grp   <= G_DIAG;
            r_sub   <= '0;
            r_e_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (i_coef.vld && o_can_load) begin
                r_busy <= 1'b1;
                r_grp  <= G_DIAG;
                r_sub  <= '0;
                r_side <= i_coef.side;
                r_val  <= i_coef.val;
            end else if (r_busy && w_en) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else if (r_sub == w_size - 3'd1) begin
                    r_grp <= w_next;
                    r_sub <= '0;
                end else begin
                    r_sub <= r_sub + 3'd1;
                end
            end
            if (w_en) begin
                r_e_vld    <= r_busy;
                r_e_row    <= w_row;
                r_e_col    <= w_col;
                r_e_k      <= w_k;
                r_e_direct <= (r_grp == G_DIAG);
                r_e_dval   <= r_side.diag;
                r_e_last   <= w_last;

                r_m_vld    <= r_e_vld;
                r_m_row    <= r_e_row;
                r_m_col    <= r_e_col;
                r_m_prod   <= i_cfg.time_step * w_kmag;
                r_m_neg    <= r_e_k > 35'sd0;
                r_m_direct <= r_e_direct;
                r_m_dval   <= r_e_dval;
                r_m_last   <= r_e_last;

                r_o_vld               <= r_m_vld;
                r_o_item.out_row      <= 24'(r_m_row);
                r_o_item.out_col      <= 24'(r_m_col);
                r_o_item.out_value    <= r_m_direct ? r_m_dval : sat32(r_m_neg, w_rnd[63:0]);
                r_o_item.last_triplet <= r_m_last;
            end
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o_item;

endmodule
